### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define NCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define NCR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/ncr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncr_pkg;

    // fixed point format: signed DATA_W bits, FRAC_BITS fraction bits
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int TOL_W      = 16;
    localparam int ITER_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // divider works on |f| << FRAC_BITS, one quotient bit per cycle
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT = CFG_ADDR_W'(1);

    localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(1);
    localparam logic [ITER_W-1:0] LIMIT_RESET = ITER_W'(64);

    typedef enum logic [STATUS_W-1:0] {
        ST_CONVERGED = 2'd0,
        ST_DZERO     = 2'd1,
        ST_LIMIT     = 2'd2
    } t_status;

    typedef struct packed {
        logic              load_x;
        logic              square;
        logic              cube;
        logic              func;
        logic              div_load;
        logic              div_step;
        logic              update;
        logic              check;
        logic              out_load;
        logic [ITER_W-1:0] iter;
        t_status           status;
    } t_cmd;

    typedef struct packed {
        logic d_zero;
        logic converged;
    } t_flags;

endpackage

`default_nettype wire

### rtl/ncr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ncr_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ncr_pkg::DATA_W-1:0] initial_guess;

    modport source (output valid, output initial_guess, input ready);
    modport sink   (input valid, input initial_guess, output ready);
endinterface

interface ncr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ncr_pkg::DATA_W-1:0]   root;
    logic        [ncr_pkg::ITER_W-1:0]   iterations;
    logic        [ncr_pkg::STATUS_W-1:0] status;

    modport source (output valid, output root, output iterations, output status, input ready);
    modport sink   (input valid, input root, input iterations, input status, output ready);
endinterface

`default_nettype wire

### rtl/ncr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ncr_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [ncr_pkg::ITER_W-1:0]   i_iter_limit,
    input  wire ncr_pkg::t_flags              i_flags,
    output ncr_pkg::t_cmd                     o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQR   = 9'b000000010,
        S_CUBE  = 9'b000000100,
        S_FUNC  = 9'b000001000,
        S_DLOAD = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_CHK   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                          r_state, n_state;
    logic [ncr_pkg::ITER_W-1:0]      r_iter, n_iter;
    logic [ncr_pkg::DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    ncr_pkg::t_status                r_status, n_status;
    logic                            r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_div_cnt   = r_div_cnt;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.iter   = r_iter;
        o_cmd.status = r_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_iter       = ncr_pkg::ITER_W'(1);
                    n_state      = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.cube = 1'b1;
                n_state    = S_FUNC;
            end
            S_FUNC: begin
                o_cmd.func = 1'b1;
                if (i_flags.d_zero) begin
                    n_status = ncr_pkg::ST_DZERO;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = ncr_pkg::DIV_CNT_W'(ncr_pkg::DIV_W - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                if (i_flags.converged) begin
                    n_status = ncr_pkg::ST_CONVERGED;
                    n_state  = S_DONE;
                end else if (r_iter >= i_iter_limit) begin
                    // limit of zero behaves as one: r_iter is at least one here
                    n_status = ncr_pkg::ST_LIMIT;
                    n_state  = S_DONE;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = S_SQR;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_iter    <= n_iter;
        r_div_cnt <= n_div_cnt;
        r_status  <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `NCR_ASSERT(a_no_result_overwrite, o_cmd.out_load |-> (!r_out_valid || i_out_ready), "result overwritten before taken")
    `NCR_ASSERT(a_accept_starts_run, (i_in_valid && o_in_ready) |=> (r_state == S_SQR && r_iter == ncr_pkg::ITER_W'(1)), "accepted transaction did not start a run")
    `NCR_ASSERT(a_div_to_update, (r_state == S_DIV && r_div_cnt == '0) |=> (r_state == S_UPD), "divider did not hand over to update")
    `NCR_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset did not clear controller")

endmodule

`default_nettype wire

### rtl/ncr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ncr_dp (
    input  wire logic                                i_clk,
    input  wire ncr_pkg::t_cmd                       i_cmd,
    input  wire logic signed [ncr_pkg::DATA_W-1:0]   i_guess,
    input  wire logic        [ncr_pkg::TOL_W-1:0]    i_tolerance,
    output ncr_pkg::t_flags                          o_flags,
    output logic signed      [ncr_pkg::DATA_W-1:0]   o_root,
    output logic             [ncr_pkg::ITER_W-1:0]   o_iterations,
    output logic             [ncr_pkg::STATUS_W-1:0] o_status
);

    localparam int DW     = ncr_pkg::DATA_W;
    localparam int FB     = ncr_pkg::FRAC_BITS;
    localparam int PROD_W = 2 * DW;
    localparam int SUM_W  = DW + 3;
    localparam int DIV_W  = ncr_pkg::DIV_W;

    localparam logic signed [DW-1:0]    D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]    D_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) << FB;

    // clamp to the signed DW-bit range
    function automatic logic signed [DW-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DW:0] hi;
        hi = v[PROD_W-1:DW-1];
        if ((&hi) || !(|hi)) begin
            return v[DW-1:0];
        end
        return v[PROD_W-1] ? D_MIN : D_MAX;
    endfunction

    function automatic logic signed [DW-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DW:0] hi;
        hi = v[SUM_W-1:DW-1];
        if ((&hi) || !(|hi)) begin
            return v[DW-1:0];
        end
        return v[SUM_W-1] ? D_MIN : D_MAX;
    endfunction

    logic signed [DW-1:0]  r_x, r_x2, r_x3, r_d, r_f, r_nx, r_root;
    logic        [DW-1:0]  r_rem, r_dvs;
    logic        [DIV_W-1:0] r_quo;
    logic                  r_neg;
    logic [ncr_pkg::ITER_W-1:0]   r_iter_out;
    logic [ncr_pkg::STATUS_W-1:0] r_status_out;

    logic signed [PROD_W-1:0] sq_prod, cu_prod;
    logic signed [SUM_W-1:0]  x_s, x2_s, x3_s, f_sum, d_sum, nx_sum, h_s;
    logic        [DW-1:0]     f_abs, d_abs;
    logic        [DW:0]       trial, trial_sub;
    logic                     ge;
    logic signed [DW-1:0]     h;
    logic                     q_big;
    logic signed [DW:0]       step;
    logic        [DW:0]       step_abs;

    always_comb begin
        sq_prod = r_x * r_x;
        cu_prod = r_x2 * r_x;

        x_s   = SUM_W'(r_x);
        x2_s  = SUM_W'(r_x2);
        x3_s  = SUM_W'(r_x3);
        f_sum = x3_s - (x_s + (x_s <<< 1)) + ONE_S;
        d_sum = (x2_s + (x2_s <<< 1)) - (ONE_S + (ONE_S <<< 1));

        f_abs = r_f[DW-1] ? DW'(-r_f) : DW'(r_f);
        d_abs = r_d[DW-1] ? DW'(-r_d) : DW'(r_d);

        // restoring divide step
        trial     = {r_rem, r_quo[DIV_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        ge        = (trial >= {1'b0, r_dvs});

        // signed, saturated quotient
        q_big = |r_quo[DIV_W-1:DW];
        if (r_neg) begin
            if (q_big || (r_quo[DW-1] && (|r_quo[DW-2:0]))) begin
                h = D_MIN;
            end else begin
                h = DW'(-r_quo[DW-1:0]);
            end
        end else begin
            if (q_big || r_quo[DW-1]) begin
                h = D_MAX;
            end else begin
                h = r_quo[DW-1:0];
            end
        end
        h_s    = SUM_W'(h);
        nx_sum = x_s - h_s;

        step     = (DW+1)'(r_nx) - (DW+1)'(r_x);
        step_abs = step[DW] ? (DW+1)'(-step) : (DW+1)'(step);

        o_flags.d_zero    = (r_d == '0);
        o_flags.converged = (step_abs <= (DW+1)'(i_tolerance));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_guess;
        end
        if (i_cmd.square) begin
            r_x2 <= sat_prod(sq_prod >>> FB);
        end
        if (i_cmd.cube) begin
            r_x3 <= sat_prod(cu_prod >>> FB);
            r_d  <= sat_sum(d_sum);
        end
        if (i_cmd.func) begin
            r_f <= sat_sum(f_sum);
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= {f_abs, {FB{1'b0}}};
            r_dvs <= d_abs;
            r_neg <= r_f[DW-1] ^ r_d[DW-1];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
        if (i_cmd.update) begin
            r_nx <= sat_sum(nx_sum);
        end
        if (i_cmd.check) begin
            r_x <= r_nx;
        end
        if (i_cmd.out_load) begin
            r_root       <= r_x;
            r_iter_out   <= i_cmd.iter;
            r_status_out <= i_cmd.status;
        end
    end

    assign o_root       = r_root;
    assign o_iterations = r_iter_out;
    assign o_status     = r_status_out;

endmodule

`default_nettype wire

### rtl/newton_cubic_root.sv
// Each Newton iteration runs square, cube, f, divider load, the one-bit divider
//   steps, update and convergence check, framed by the accept and output states;
//   a zero-derivative iteration ends after f.
// One transaction is handled per run; the divider loop sets the pace.
// The next transaction is taken as soon as the result sits in the output register.
// Reset: synchronous active-low; clears the FSM and output valid, tolerance 1, limit 64.
`timescale 1ns / 1ps
`default_nettype none

module newton_cubic_root (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ncr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [ncr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ncr_in_if.sink                                 i_in,
    ncr_out_if.source                              o_out
);

    // configuration registers: user writes only with no transaction in flight; unchecked
    logic [ncr_pkg::TOL_W-1:0]  r_tolerance;
    logic [ncr_pkg::ITER_W-1:0] r_iter_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance  <= ncr_pkg::TOL_RESET;
            r_iter_limit <= ncr_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ncr_pkg::CFG_TOLERANCE: begin
                    r_tolerance <= i_cfg_data[ncr_pkg::TOL_W-1:0];
                end
                ncr_pkg::CFG_ITER_LIMIT: begin
                    r_iter_limit <= i_cfg_data[ncr_pkg::ITER_W-1:0];
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // controller sequences one iteration at a time; datapath holds the
    // estimate, the two multipliers, the serial divider and the result register
    ncr_pkg::t_cmd   w_cmd;
    ncr_pkg::t_flags w_flags;

    ncr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .i_iter_limit (r_iter_limit),
        .i_flags      (w_flags),
        .o_cmd        (w_cmd)
    );

    ncr_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_guess      (i_in.initial_guess),
        .i_tolerance  (r_tolerance),
        .o_flags      (w_flags),
        .o_root       (o_out.root),
        .o_iterations (o_out.iterations),
        .o_status     (o_out.status)
    );

endmodule

`default_nettype wire

### tb/newton_cubic_root_test.sv
`timescale 1ns / 1ps

module newton_cubic_root_test;

    // Q16.16 limits and unity, widened so the root solver never overflows
    localparam longint FX_MAX = 64'sd2147483647;
    localparam longint FX_MIN = -64'sd2147483648;
    localparam longint ONE_FX = longint'(1) << ncr_pkg::FRAC_BITS;

    // Register indexes past the end of the map; writes to them must be dropped
    localparam logic [ncr_pkg::CFG_ADDR_W-1:0] CFG_SPARE_LO = ncr_pkg::CFG_ADDR_W'(2);
    localparam logic [ncr_pkg::CFG_ADDR_W-1:0] CFG_SPARE_HI = ncr_pkg::CFG_ADDR_W'(3);

    // Long output back-pressure: starts once this many roots have come out
    localparam int LONG_HOLD_AT     = 40;
    localparam int LONG_HOLD_CYCLES = 1500;

    // Slowest single run (255 iterations), plus the long hold and a few idle bursts,
    // taken about four times over.
    localparam int WATCHDOG_CYCLES = 60000;

    // Drain tail, to catch stray transactions
    localparam int TAIL_CYCLES = 120;

    typedef struct packed {
        logic signed [ncr_pkg::DATA_W-1:0] root;
        logic [ncr_pkg::ITER_W-1:0]        iterations;
        ncr_pkg::t_status                  status;
    } t_cubic_root;

    logic i_clk;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [ncr_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [ncr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ncr_in_if  in_ch ();
    ncr_out_if out_ch ();

    newton_cubic_root u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Local copy of the register file, updated as each write lands
    logic [ncr_pkg::TOL_W-1:0]  tol_setting;
    logic [ncr_pkg::ITER_W-1:0] limit_setting;

    logic signed [ncr_pkg::DATA_W-1:0] guesses_pending[$];   // waiting to be offered
    t_cubic_root                       solutions_due[$];     // roots owed by the block

    bit send_idle_en;
    bit take_idle_en;
    int send_gap;
    int take_gap;
    int hold_left;
    bit long_hold_done;
    int quiet_cycles;

    int guesses_taken;
    int results_checked;
    int mismatches;
    int reg_writes;
    int n_converged;
    int n_dzero;
    int n_limit;

    t_cubic_root want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > FX_MAX) return FX_MAX;
        if (v < FX_MIN) return FX_MIN;
        return v;
    endfunction

    // Newton-Raphson on x^3 - 3x + 1 with the current register settings.
    // Every computed value but the step size saturates to 32 bits; >>> on a signed longint floors.
    function automatic t_cubic_root solve_cubic(
        input logic signed [ncr_pkg::DATA_W-1:0] guess);
        longint x, x2, x3, fx, dfx, h, nx, step_mag;
        int unsigned cap, k;
        t_cubic_root r;
        x   = guess;
        cap = (limit_setting == 0) ? 1 : limit_setting;   // a limit of 0 still runs once
        k   = 0;
        while (1) begin
            k++;
            x2  = clamp32((x * x) >>> ncr_pkg::FRAC_BITS);
            x3  = clamp32((x2 * x) >>> ncr_pkg::FRAC_BITS);
            fx  = clamp32(x3 - 3 * x + ONE_FX);
            dfx = clamp32(3 * x2 - 3 * ONE_FX);
            if (dfx == 0) begin
                // flat slope: give back the current estimate, iteration counted
                r.status = ncr_pkg::ST_DZERO;
                r.root   = x[ncr_pkg::DATA_W-1:0];
                break;
            end
            h        = clamp32((fx * ONE_FX) / dfx);   // truncates toward zero
            nx       = clamp32(x - h);
            step_mag = (nx > x) ? nx - x : x - nx;
            if (step_mag <= longint'(tol_setting)) begin
                r.status = ncr_pkg::ST_CONVERGED;
                r.root   = nx[ncr_pkg::DATA_W-1:0];
                break;
            end
            if (k >= cap) begin
                r.status = ncr_pkg::ST_LIMIT;
                r.root   = nx[ncr_pkg::DATA_W-1:0];
                break;
            end
            x = nx;
        end
        r.iterations = k[ncr_pkg::ITER_W-1:0];
        return r;
    endfunction

    // Mostly guesses within +-5.0, some within 32 LSB of the flat points +-1.0,
    // and a share of full-range words that saturate and usually run to the limit.
    function automatic logic signed [ncr_pkg::DATA_W-1:0] pick_guess(
        input int unsigned wide_pct);
        int unsigned roll;
        int mag;
        roll = $urandom_range(99);
        if (roll < wide_pct)
            return $urandom;
        if (roll < wide_pct + 8)
            mag = (1 << ncr_pkg::FRAC_BITS) + int'($urandom_range(64)) - 32;
        else
            mag = int'($urandom_range(5 << ncr_pkg::FRAC_BITS));
        return ($urandom_range(1) != 0) ? -mag : mag;
    endfunction

    // Input driver: a new transaction is offered only once the last one was taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                solutions_due.push_back(solve_cubic(in_ch.initial_guess));
                guesses_taken++;
            end
            if (send_gap != 0) begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (guesses_pending.size() != 0) begin
                if (send_idle_en && $urandom_range(5) == 0) begin
                    send_gap    <= $urandom_range(2);   // random idle gap, this cycle included
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid         <= 1'b1;
                    in_ch.initial_guess <= guesses_pending.pop_front();
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result transaction and throttles ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            take_gap       <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (solutions_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: root=%h iterations=%0d status=%0d",
                             $time, out_ch.root, out_ch.iterations, out_ch.status);
                end else begin
                    want = solutions_due.pop_front();
                    if (out_ch.root !== want.root || out_ch.iterations !== want.iterations ||
                        out_ch.status !== want.status) begin
                        mismatches++;
                        $display("%0t: mismatch: expected root=%h iterations=%0d status=%0d, %s",
                                 $time, want.root, want.iterations, want.status, "got");
                        $display("%0t:           actual   root=%h iterations=%0d status=%0d",
                                 $time, out_ch.root, out_ch.iterations, out_ch.status);
                    end
                    case (want.status)
                        ncr_pkg::ST_CONVERGED: n_converged++;
                        ncr_pkg::ST_DZERO:     n_dzero++;
                        default:               n_limit++;
                    endcase
                end
                results_checked++;
            end

            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (!long_hold_done && results_checked == LONG_HOLD_AT) begin
                // long back-pressure while the driver keeps offering: input must stall
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD_CYCLES - 1;
                out_ch.ready   <= 1'b0;
            end else if (take_gap != 0) begin
                take_gap     <= take_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (take_idle_en && $urandom_range(3) == 0) begin
                take_gap     <= $urandom_range(2);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d roots outstanding",
                     $time, WATCHDOG_CYCLES, solutions_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Waits until every guess is taken and every root has come back
    task automatic settle();
        do @(negedge i_clk);
        while (guesses_pending.size() != 0 || in_ch.valid || solutions_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ncr_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [ncr_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            ncr_pkg::CFG_TOLERANCE:  tol_setting   = val[ncr_pkg::TOL_W-1:0];
            ncr_pkg::CFG_ITER_LIMIT: limit_setting = val[ncr_pkg::ITER_W-1:0];
            default: ;   // out-of-map index, no effect
        endcase
        reg_writes++;
    endtask

    // One random phase: set both registers (junk in the unused limit bits),
    // queue the guesses and wait for all roots.
    task automatic run_phase(input logic [ncr_pkg::TOL_W-1:0] tol,
                             input logic [ncr_pkg::ITER_W-1:0] lim,
                             input int n, input int unsigned wide_pct, input bit idle);
        write_reg(ncr_pkg::CFG_TOLERANCE, tol);
        write_reg(ncr_pkg::CFG_ITER_LIMIT, {8'($urandom), lim});
        send_idle_en = idle;
        take_idle_en = idle;
        repeat (n) guesses_pending.push_back(pick_guess(wide_pct));
        settle();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_addr          = ncr_pkg::CFG_TOLERANCE;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.initial_guess = '0;
        out_ch.ready        = 1'b0;
        tol_setting         = ncr_pkg::TOL_RESET;
        limit_setting       = ncr_pkg::LIMIT_RESET;
        send_idle_en        = 1'b1;
        take_idle_en        = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: flat points, zero, one LSB, +-2, extremes, near each root
        guesses_pending = '{32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_0000,
                            32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0002_0000,
                            32'shFFFE_0000, 32'sh0000_8000, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh0001_8000, 32'shFFFE_2000,
                            32'sh0000_5900};
        settle();

        // Limit of zero behaves as one; upper data byte is junk
        write_reg(ncr_pkg::CFG_ITER_LIMIT, 16'hA500);
        guesses_pending = '{32'sh0003_0000, 32'sh8000_0000};
        settle();

        // Widest tolerance, single iteration
        write_reg(ncr_pkg::CFG_TOLERANCE, 16'hFFFF);
        write_reg(ncr_pkg::CFG_ITER_LIMIT, 16'h0001);
        guesses_pending = '{32'sh0002_0000, 32'sh0000_0000};
        settle();

        // Exact convergence only, longest run from a saturated guess
        write_reg(ncr_pkg::CFG_TOLERANCE, 16'h0000);
        write_reg(ncr_pkg::CFG_ITER_LIMIT, 16'h5AFF);
        guesses_pending = '{32'sh7FFF_FFFF, 32'sh0000_4000};
        settle();

        // Writes past the register map must leave both settings alone
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        guesses_pending = '{32'shFFFF_0000, 32'sh0000_5555};
        settle();

        // Random phases; the long output hold lands in the first one
        run_phase(16'd1, 8'd64, 100, 8, 1'b1);
        run_phase(16'($urandom_range(2, 300)), 8'($urandom_range(1, 32)), 90, 10, 1'b1);
        run_phase(16'($urandom_range(1000, 65535)), 8'd255, 80, 3, 1'b1);
        run_phase(16'd0, 8'd16, 80, 10, 1'b1);
        run_phase(16'd1, 8'd64, 100, 5, 1'b0);   // closing stretch, no idling

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Summary: %0d guesses, %0d roots checked, %0d register writes",
                 guesses_taken, results_checked, reg_writes);
        $display("Outcomes: %0d converged, %0d zero slope, %0d hit the limit; %0d bad",
                 n_converged, n_dzero, n_limit, mismatches);
        if (mismatches == 0 && solutions_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
